[hw/rtl/nmfc_pkg.sv]
`timescale 1ns / 1ps
// ============================================================================
// nmfc_pkg - shared types and constants of the NCO mixer / FIR channel
// Request codes, register map, and the fixed-point constants of the CORDIC
// sine generator.
// ============================================================================
package nmfc_pkg;

    localparam int REQ_W = 2;

    localparam logic [REQ_W-1:0] REQ_SAMPLE  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_TAP     = 2'd1;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd2;

    localparam int ADDR_W = 3;
    localparam int DATA_W = 32;

    localparam logic REG_PHASE_STEP = 1'b0;
    localparam logic REG_BYPASS     = 1'b1;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 34;
    localparam int STEP_W       = 5;
    localparam int SINE_W       = 16;
    localparam int SINE_FRAC    = 15;

    typedef logic signed [CORDIC_W-1:0] t_cordic;
    typedef logic signed [SINE_W-1:0]   t_sine;

    localparam t_cordic CORDIC_X0  = 34'sd652032874;
    localparam t_cordic CORDIC_QTR = 34'sd1073741824;
    localparam t_cordic CORDIC_HLF = 34'sd2147483648;
    localparam t_cordic SINE_MAX   = 34'sd32767;
    localparam t_cordic SINE_RND   = 34'sd16384;

    function automatic t_cordic f_atan(input logic [STEP_W-1:0] i);
        t_cordic a;
        case (i)
            5'd0:    a = 34'sd536870912;
            5'd1:    a = 34'sd316933406;
            5'd2:    a = 34'sd167458907;
            5'd3:    a = 34'sd85004756;
            5'd4:    a = 34'sd42667331;
            5'd5:    a = 34'sd21354465;
            5'd6:    a = 34'sd10679838;
            5'd7:    a = 34'sd5340245;
            5'd8:    a = 34'sd2670163;
            5'd9:    a = 34'sd1335087;
            5'd10:   a = 34'sd667544;
            5'd11:   a = 34'sd333772;
            5'd12:   a = 34'sd166886;
            5'd13:   a = 34'sd83443;
            5'd14:   a = 34'sd41722;
            5'd15:   a = 34'sd20861;
            5'd16:   a = 34'sd10430;
            5'd17:   a = 34'sd5215;
            5'd18:   a = 34'sd2608;
            5'd19:   a = 34'sd1304;
            5'd20:   a = 34'sd652;
            5'd21:   a = 34'sd326;
            5'd22:   a = 34'sd163;
            5'd23:   a = 34'sd81;
            default: a = '0;
        endcase
        return a;
    endfunction

endpackage

[hw/rtl/nmfc_req_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// nmfc_req_if - request channel of the NCO mixer / FIR channel
// Valid/ready channel carrying samples, tap writes and restarts.
// ============================================================================
interface nmfc_req_if #(
    parameter int SAMPLE_BITS = 16,
    parameter int COEF_BITS   = 18
);
    logic                            valid;
    logic                            ready;
    logic [nmfc_pkg::REQ_W-1:0]      req_type;
    logic signed [SAMPLE_BITS-1:0]   sample_i;
    logic signed [SAMPLE_BITS-1:0]   sample_q;
    logic [4:0]                      tap_index;
    logic signed [COEF_BITS-1:0]     tap_value;

    modport source (
        output valid, req_type, sample_i, sample_q, tap_index, tap_value,
        input  ready
    );
    modport sink (
        input  valid, req_type, sample_i, sample_q, tap_index, tap_value,
        output ready
    );
endinterface

[hw/rtl/nmfc_res_if.sv]
`timescale 1ns / 1ps
// ============================================================================
// nmfc_res_if - result channel of the NCO mixer / FIR channel
// Valid/ready channel carrying one filtered (or bypassed) I/Q word per sample.
// ============================================================================
interface nmfc_res_if #(
    parameter int SAMPLE_BITS = 16
);
    logic                            valid;
    logic                            ready;
    logic signed [SAMPLE_BITS-1:0]   out_i;
    logic signed [SAMPLE_BITS-1:0]   out_q;

    modport source (
        output valid, out_i, out_q,
        input  ready
    );
    modport sink (
        input  valid, out_i, out_q,
        output ready
    );
endinterface

[hw/rtl/nco_mix_fir_channel_core.sv]
`timescale 1ns / 1ps
// ============================================================================
// nco_mix_fir_channel_core - NCO mixer and complex FIR channel slot
// Unless bypassed, mixes I/Q samples by a CORDIC-generated NCO, filters them
// with a NUM_TAPS-tap FIR on one shared multiplier, rounds and saturates.
// ============================================================================
// A mixed sample occupies the block until it is finished, one word at a
// time: the CORDIC unit runs 24 iterations for the sine and 24 for the
// cosine, and a single multiplier then makes four mixer products and two FIR
// products per tap (I and Q). In bypass a sample goes straight to the
// finished word; tap writes and restarts leave the block idle. The finished
// word sits in an output register, so the next request is taken while it
// waits. The delay line and coefficient store carry one valid bit per entry,
// so reset clears both and restart clears the delay line at once, no sweep.
module nco_mix_fir_channel_core #(
    parameter int NUM_TAPS       = 31,
    parameter int SAMPLE_BITS    = 16,
    parameter int COEF_BITS      = 18,
    parameter int PHASE_LUT_BITS = 10
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    nmfc_req_if.sink                      i_req,
    nmfc_res_if.source                    o_res,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [nmfc_pkg::ADDR_W-1:0]   paddr,
    input  logic [nmfc_pkg::DATA_W-1:0]   pwdata,
    output logic [nmfc_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    localparam int TA    = $clog2(NUM_TAPS);
    localparam int KW    = $clog2(NUM_TAPS + 1);
    localparam int MA    = (COEF_BITS > nmfc_pkg::SINE_W) ? COEF_BITS : nmfc_pkg::SINE_W;
    localparam int PW    = MA + SAMPLE_BITS;
    localparam int ACC_W = PW + TA + 1;
    localparam int PLB   = PHASE_LUT_BITS;

    localparam logic [TA-1:0]  LAST_ADDR = TA'(NUM_TAPS - 1);
    localparam logic [KW-1:0]  TAP_CNT   = KW'(NUM_TAPS);
    localparam logic [PLB-1:0] QTR_IDX   = PLB'(1 << (PLB - 2));
    localparam logic [nmfc_pkg::STEP_W-1:0] LAST_STEP =
        nmfc_pkg::STEP_W'(nmfc_pkg::CORDIC_STEPS - 1);
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'((1 << (SAMPLE_BITS - 1)) - 1);
    localparam logic signed [ACC_W-1:0] SAT_LO = ~SAT_HI;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CINIT  = 4'd1;
    localparam logic [3:0] S_CSTEP  = 4'd2;
    localparam logic [3:0] S_CFIN   = 4'd3;
    localparam logic [3:0] S_MIX    = 4'd4;
    localparam logic [3:0] S_MIXEND = 4'd5;
    localparam logic [3:0] S_MIXWR  = 4'd6;
    localparam logic [3:0] S_FRD    = 4'd7;
    localparam logic [3:0] S_FI     = 4'd8;
    localparam logic [3:0] S_FQ     = 4'd9;
    localparam logic [3:0] S_FDRAIN = 4'd10;
    localparam logic [3:0] S_FOUT   = 4'd11;
    localparam logic [3:0] S_DONE   = 4'd12;

    function automatic logic signed [SAMPLE_BITS-1:0] f_round_sat(
        input logic signed [ACC_W-1:0] acc,
        input int                      sh
    );
        logic signed [ACC_W-1:0] v;
        v = acc + $signed(ACC_W'(1) << (sh - 1));
        v = v >>> sh;
        if (v > SAT_HI) begin
            v = SAT_HI;
        end else if (v < SAT_LO) begin
            v = SAT_LO;
        end
        return v[SAMPLE_BITS-1:0];
    endfunction

    // control and configuration
    logic [3:0]                     r_state;
    logic signed [31:0]             r_phase_step;
    logic                           r_bypass;
    logic [31:0]                    r_phase_acc;
    logic [TA-1:0]                  r_wp;

    // sample and NCO
    logic signed [SAMPLE_BITS-1:0]  r_si, r_sq;
    logic [PLB-1:0]                 r_idx;
    logic                           r_pass;
    nmfc_pkg::t_cordic              r_x, r_y, r_z;
    logic                           r_neg;
    logic [nmfc_pkg::STEP_W-1:0]    r_step;
    nmfc_pkg::t_sine                r_sin, r_cos;
    logic [1:0]                     r_cnt;

    // FIR walk
    logic [KW-1:0]                  r_k;
    logic [TA-1:0]                  r_d;
    logic                           r_more;
    logic signed [MA-1:0]           r_h_coef;
    logic signed [SAMPLE_BITS-1:0]  r_h_q;

    // shared multiplier and accumulators
    logic signed [PW-1:0]           r_prod;
    logic                           r_p_vld, r_p_q, r_p_neg;
    logic signed [ACC_W-1:0]        r_acc_i, r_acc_q;

    // memories
    logic [2*SAMPLE_BITS-1:0]       dl_mem [NUM_TAPS];
    logic [NUM_TAPS-1:0]            r_dl_vld;
    logic [2*SAMPLE_BITS-1:0]       r_dl_rd;
    logic                           r_dl_rd_vld;
    logic signed [COEF_BITS-1:0]    cf_mem [NUM_TAPS];
    logic [NUM_TAPS-1:0]            r_cf_vld;
    logic signed [COEF_BITS-1:0]    r_cf_rd;
    logic                           r_cf_rd_vld;

    // output
    logic signed [SAMPLE_BITS-1:0]  r_res_i, r_res_q;
    logic                           r_out_vld;
    logic signed [SAMPLE_BITS-1:0]  r_out_i, r_out_q;

    logic                           in_acc, cfg_wr, tap_ok, rd_en, out_load, acc_clr;
    logic [TA-1:0]                  tap_addr, d_dec;
    logic [PLB-1:0]                 c_idx;
    logic [31:0]                    ang;
    nmfc_pkg::t_cordic              z0, dx, dy, atn, sv, sv_sat;
    logic signed [MA-1:0]           mul_a, cf_eff;
    logic signed [SAMPLE_BITS-1:0]  mul_b, dl_i_eff, dl_q_eff, mix_i, mix_q;
    logic                           mul_en, mul_q, mul_neg;

    // ------------------------------------------------------------------
    // configuration port
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;
    assign prdata = (paddr[2] == nmfc_pkg::REG_PHASE_STEP) ? r_phase_step
                                                            : {31'd0, r_bypass};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= '0;
            r_bypass     <= 1'b1;
        end else if (cfg_wr) begin
            if (paddr[2] == nmfc_pkg::REG_PHASE_STEP) begin
                r_phase_step <= pwdata;
            end else begin
                r_bypass <= pwdata[0];
            end
        end
    end

    // ------------------------------------------------------------------
    // combinational helpers
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid & i_req.ready;
    assign tap_ok      = (32'(i_req.tap_index) < NUM_TAPS);
    assign tap_addr    = TA'(i_req.tap_index);
    assign d_dec       = (r_d == '0) ? LAST_ADDR : r_d - TA'(1);
    assign out_load    = (r_state == S_DONE) && (!r_out_vld || o_res.ready);
    assign acc_clr     = (r_state == S_IDLE) || (r_state == S_MIXWR);

    assign c_idx = r_idx + QTR_IDX;
    assign ang   = {(r_pass ? c_idx : r_idx), {(32 - PLB){1'b0}}};
    assign z0    = nmfc_pkg::CORDIC_W'($signed(ang));
    assign dx    = r_y >>> r_step;
    assign dy    = r_x >>> r_step;
    assign atn   = nmfc_pkg::f_atan(r_step);

    always_comb begin
        sv = (r_y + nmfc_pkg::SINE_RND) >>> nmfc_pkg::SINE_FRAC;
        if (sv > nmfc_pkg::SINE_MAX) begin
            sv_sat = nmfc_pkg::SINE_MAX;
        end else if (sv < -nmfc_pkg::SINE_MAX) begin
            sv_sat = -nmfc_pkg::SINE_MAX;
        end else begin
            sv_sat = sv;
        end
        if (r_neg) begin
            sv_sat = -sv_sat;
        end
    end

    assign cf_eff   = r_cf_rd_vld ? MA'(r_cf_rd) : '0;
    assign dl_i_eff = r_dl_rd_vld ? $signed(r_dl_rd[SAMPLE_BITS-1:0]) : '0;
    assign dl_q_eff = r_dl_rd_vld ? $signed(r_dl_rd[2*SAMPLE_BITS-1:SAMPLE_BITS]) : '0;
    assign mix_i    = f_round_sat(r_acc_i, nmfc_pkg::SINE_FRAC);
    assign mix_q    = f_round_sat(r_acc_q, nmfc_pkg::SINE_FRAC);
    assign rd_en    = (r_state == S_FRD) || ((r_state == S_FI) && (r_k != TAP_CNT));

    // operand select for the shared multiplier
    always_comb begin
        mul_a   = '0;
        mul_b   = '0;
        mul_en  = 1'b0;
        mul_q   = 1'b0;
        mul_neg = 1'b0;
        case (r_state)
            S_MIX: begin
                mul_en = 1'b1;
                case (r_cnt)
                    2'd0: begin
                        mul_a = MA'(r_cos);
                        mul_b = r_si;
                    end
                    2'd1: begin
                        mul_a   = MA'(r_sin);
                        mul_b   = r_sq;
                        mul_neg = 1'b1;
                    end
                    2'd2: begin
                        mul_a = MA'(r_sin);
                        mul_b = r_si;
                        mul_q = 1'b1;
                    end
                    default: begin
                        mul_a = MA'(r_cos);
                        mul_b = r_sq;
                        mul_q = 1'b1;
                    end
                endcase
            end
            S_FI: begin
                mul_en = 1'b1;
                mul_a  = cf_eff;
                mul_b  = dl_i_eff;
            end
            S_FQ: begin
                mul_en = 1'b1;
                mul_a  = r_h_coef;
                mul_b  = r_h_q;
                mul_q  = 1'b1;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_prod  <= mul_a * mul_b;
        r_p_q   <= mul_q;
        r_p_neg <= mul_neg;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else begin
            r_p_vld <= mul_en;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_clr) begin
            r_acc_i <= '0;
            r_acc_q <= '0;
        end else if (r_p_vld) begin
            if (r_p_q) begin
                r_acc_q <= r_p_neg ? r_acc_q - ACC_W'(r_prod) : r_acc_q + ACC_W'(r_prod);
            end else begin
                r_acc_i <= r_p_neg ? r_acc_i - ACC_W'(r_prod) : r_acc_i + ACC_W'(r_prod);
            end
        end
    end

    // ------------------------------------------------------------------
    // delay line and coefficient store
    always_ff @(posedge i_clk) begin
        if (r_state == S_MIXWR) begin
            dl_mem[r_wp] <= {mix_q, mix_i};
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_dl_rd     <= dl_mem[r_d];
            r_dl_rd_vld <= r_dl_vld[r_d];
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && (i_req.req_type == nmfc_pkg::REQ_TAP) && tap_ok) begin
            cf_mem[tap_addr] <= i_req.tap_value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_cf_rd     <= cf_mem[r_k[TA-1:0]];
            r_cf_rd_vld <= r_cf_vld[r_k[TA-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cf_vld <= '0;
        end else if (in_acc && (i_req.req_type == nmfc_pkg::REQ_TAP) && tap_ok) begin
            r_cf_vld[tap_addr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dl_vld <= '0;
        end else if (in_acc && (i_req.req_type == nmfc_pkg::REQ_RESTART)) begin
            r_dl_vld <= '0;
        end else if (r_state == S_MIXWR) begin
            r_dl_vld[r_wp] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_phase_acc <= '0;
            r_wp        <= '0;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        case (i_req.req_type)
                            nmfc_pkg::REQ_SAMPLE: begin
                                r_si <= i_req.sample_i;
                                r_sq <= i_req.sample_q;
                                if (r_bypass) begin
                                    r_res_i <= i_req.sample_i;
                                    r_res_q <= i_req.sample_q;
                                    r_state <= S_DONE;
                                end else begin
                                    r_idx       <= r_phase_acc[31 -: PLB];
                                    r_phase_acc <= r_phase_acc + r_phase_step;
                                    r_pass      <= 1'b0;
                                    r_state     <= S_CINIT;
                                end
                            end
                            nmfc_pkg::REQ_RESTART: begin
                                r_phase_acc <= '0;
                                r_wp        <= '0;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_CINIT: begin
                    r_x    <= nmfc_pkg::CORDIC_X0;
                    r_y    <= '0;
                    r_step <= '0;
                    if (z0 > nmfc_pkg::CORDIC_QTR) begin
                        r_z   <= z0 - nmfc_pkg::CORDIC_HLF;
                        r_neg <= 1'b1;
                    end else if (z0 < -nmfc_pkg::CORDIC_QTR) begin
                        r_z   <= z0 + nmfc_pkg::CORDIC_HLF;
                        r_neg <= 1'b1;
                    end else begin
                        r_z   <= z0;
                        r_neg <= 1'b0;
                    end
                    r_state <= S_CSTEP;
                end
                S_CSTEP: begin
                    if (!r_z[nmfc_pkg::CORDIC_W-1]) begin
                        r_x <= r_x - dx;
                        r_y <= r_y + dy;
                        r_z <= r_z - atn;
                    end else begin
                        r_x <= r_x + dx;
                        r_y <= r_y - dy;
                        r_z <= r_z + atn;
                    end
                    r_step <= r_step + 1'b1;
                    if (r_step == LAST_STEP) begin
                        r_state <= S_CFIN;
                    end
                end
                S_CFIN: begin
                    if (!r_pass) begin
                        r_sin   <= sv_sat[nmfc_pkg::SINE_W-1:0];
                        r_pass  <= 1'b1;
                        r_state <= S_CINIT;
                    end else begin
                        r_cos   <= sv_sat[nmfc_pkg::SINE_W-1:0];
                        r_cnt   <= '0;
                        r_state <= S_MIX;
                    end
                end
                S_MIX: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (r_cnt == 2'd3) begin
                        r_state <= S_MIXEND;
                    end
                end
                S_MIXEND: begin
                    r_state <= S_MIXWR;
                end
                S_MIXWR: begin
                    r_k     <= '0;
                    r_d     <= r_wp;
                    r_state <= S_FRD;
                end
                S_FRD: begin
                    r_k     <= r_k + 1'b1;
                    r_d     <= d_dec;
                    r_state <= S_FI;
                end
                S_FI: begin
                    r_h_coef <= cf_eff;
                    r_h_q    <= dl_q_eff;
                    r_more   <= (r_k != TAP_CNT);
                    if (r_k != TAP_CNT) begin
                        r_k <= r_k + 1'b1;
                        r_d <= d_dec;
                    end
                    r_state <= S_FQ;
                end
                S_FQ: begin
                    r_state <= r_more ? S_FI : S_FDRAIN;
                end
                S_FDRAIN: begin
                    r_state <= S_FOUT;
                end
                S_FOUT: begin
                    r_res_i <= f_round_sat(r_acc_i, COEF_BITS - 1);
                    r_res_q <= f_round_sat(r_acc_q, COEF_BITS - 1);
                    r_wp    <= (r_wp == LAST_ADDR) ? '0 : r_wp + TA'(1);
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // output register
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_i <= r_res_i;
            r_out_q <= r_res_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (out_load) begin
            r_out_vld <= 1'b1;
        end else if (o_res.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    assign o_res.valid = r_out_vld;
    assign o_res.out_i = r_out_i;
    assign o_res.out_q = r_out_q;

    // ------------------------------------------------------------------
    // assertions
    a_phase_adv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req.req_type == nmfc_pkg::REQ_SAMPLE) && !r_bypass)
        |=> (r_phase_acc == $past(r_phase_acc) + $past(r_phase_step)))
        else $error("phase accumulator did not advance by one step");

    a_restart_clr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && (i_req.req_type == nmfc_pkg::REQ_RESTART))
        |=> ((r_dl_vld == '0) && (r_phase_acc == '0) && (r_wp == '0)))
        else $error("restart left delay line or phase state behind");

    a_prod_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_p_vld |-> ((r_state == S_MIX) || (r_state == S_MIXEND) ||
                     (r_state == S_FI) || (r_state == S_FQ) || (r_state == S_FDRAIN)))
        else $error("product landed outside a multiply-accumulate phase");

endmodule
